### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// concurrent check sampled on clk, silent while rst is high
`define SBA_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sba check failed");
// concurrent check that also holds across reset
`define SBA_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sba check failed across reset");
`endif

### rtl/sba_pkg.sv
package sba_pkg;

  typedef enum logic [1:0] {
    ST_FREE = 2'd0,
    ST_HEAD = 2'd1,
    ST_CONT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OUT_NEW      = 3'd0,
    OUT_HIT      = 3'd1,
    OUT_OOM      = 3'd2,
    OUT_LOWERED  = 3'd3,
    OUT_RELEASED = 3'd4,
    OUT_IGNORED  = 3'd5
  } outcome_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_FIT,
    S_MARK,
    S_RELEASE,
    S_DONE
  } state_t;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 16;
  localparam int IDX_OUT_W  = 10;

endpackage

### rtl/shared_block_allocator.sv
// passes: a release runs the release pass, a shared hit the match pass, a new allocation
// the match, first-fit and marking passes, and out of memory the match and first-fit passes
// throughput: one transaction at a time, set by the block map rotating once per pass
// through the chain of cells; the next request is taken while a result waits
// reset: synchronous, every block free and bitmap_mode 0, no clearing pass
module shared_block_allocator #(
  parameter int NUM_BLOCKS      = 1024,
  parameter int BLOCK_BYTES     = 32,
  parameter int RESERVED_BLOCKS = 512,
  parameter int REF_WIDTH       = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: bitmap_mode
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // key_hash [31:0], size_bytes [47:32], handle [57:48], zero fill above
  input  logic [63:0] s_axis_tdata,
  // kind [0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // block_index [9:0], zero fill above
  output logic [15:0] m_axis_tdata,
  // outcome [2:0]
  output logic [2:0]  m_axis_tuser
);

  // mode register only moves the start of the searches
  logic bitmap_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      bitmap_mode <= 1'b0;
    end else if (cfg_we) begin
      bitmap_mode <= cfg_wdata;
    end
  end

  // ring of cells: cell k holds block (pos + k) mod N, cell 0 feeds the engine
  // and the engine's edited entry re-enters at the far end
  sba_pkg::status_t     st_q   [NUM_BLOCKS];
  logic [31:0]          key_q  [NUM_BLOCKS];
  logic [REF_WIDTH-1:0] refs_q [NUM_BLOCKS];
  sba_pkg::status_t     tail_status;
  logic [31:0]          tail_key;
  logic [REF_WIDTH-1:0] tail_refs;
  logic                 shift;

  for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_cell
    if (k == NUM_BLOCKS - 1) begin : g_tail
      sba_cell #(.REF_WIDTH(REF_WIDTH)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (shift),
        .d_status (tail_status),
        .d_key    (tail_key),
        .d_refs   (tail_refs),
        .q_status (st_q[k]),
        .q_key    (key_q[k]),
        .q_refs   (refs_q[k])
      );
    end else begin : g_mid
      sba_cell #(.REF_WIDTH(REF_WIDTH)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (shift),
        .d_status (st_q[k+1]),
        .d_key    (key_q[k+1]),
        .d_refs   (refs_q[k+1]),
        .q_status (st_q[k]),
        .q_key    (key_q[k]),
        .q_refs   (refs_q[k])
      );
    end
  end

  // sequencer: match pass, first-fit pass, marking pass, or one release pass
  sba_engine #(
    .NUM_BLOCKS      (NUM_BLOCKS),
    .BLOCK_BYTES     (BLOCK_BYTES),
    .RESERVED_BLOCKS (RESERVED_BLOCKS),
    .REF_WIDTH       (REF_WIDTH)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .bitmap_mode   (bitmap_mode),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .head_status   (st_q[0]),
    .head_key      (key_q[0]),
    .head_refs     (refs_q[0]),
    .tail_status   (tail_status),
    .tail_key      (tail_key),
    .tail_refs     (tail_refs),
    .shift         (shift)
  );

endmodule

### rtl/sba_cell.sv
module sba_cell #(
  parameter int REF_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 shift,
  input  sba_pkg::status_t     d_status,
  input  logic [31:0]          d_key,
  input  logic [REF_WIDTH-1:0] d_refs,
  output sba_pkg::status_t     q_status,
  output logic [31:0]          q_key,
  output logic [REF_WIDTH-1:0] q_refs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_status <= sba_pkg::ST_FREE;
    end else if (shift) begin
      q_status <= d_status;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (shift) begin
      q_key  <= d_key;
      q_refs <= d_refs;
    end
  end

endmodule

### rtl/sba_engine.sv
module sba_engine #(
  parameter int NUM_BLOCKS      = 1024,
  parameter int BLOCK_BYTES     = 32,
  parameter int RESERVED_BLOCKS = 512,
  parameter int REF_WIDTH       = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           bitmap_mode,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [sba_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [0:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [sba_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [2:0]                     m_axis_tuser,
  input  sba_pkg::status_t               head_status,
  input  logic [31:0]                    head_key,
  input  logic [REF_WIDTH-1:0]           head_refs,
  output sba_pkg::status_t               tail_status,
  output logic [31:0]                    tail_key,
  output logic [REF_WIDTH-1:0]           tail_refs,
  output logic                           shift
);

  localparam int IDX_W     = $clog2(NUM_BLOCKS);
  localparam int CW        = (IDX_W + 1 > 11) ? IDX_W + 1 : 11;
  localparam int START_CAP = (RESERVED_BLOCKS > NUM_BLOCKS) ? NUM_BLOCKS : RESERVED_BLOCKS;
  localparam int AW        = $clog2(65535 + BLOCK_BYTES + 1);

  sba_pkg::state_t   state, state_next;
  sba_pkg::outcome_t code, code_next;
  sba_pkg::outcome_t res_code, res_code_next;
  logic [IDX_W-1:0]  pos, pos_next, pos_inc;
  logic [IDX_W-1:0]  sel, sel_next;
  logic [31:0]       key_r, key_r_next;
  logic [15:0]       size_r, size_r_next;
  logic [9:0]        handle_r, handle_r_next;
  logic              found, found_next;
  logic [AW-1:0]     acc, acc_next, acc_add;
  logic [9:0]        out_idx, out_idx_next;
  logic [9:0]        res_idx, res_idx_next;
  logic              m_valid_next;
  logic              last, ge_start;
  logic [CW-1:0]     start_x;
  logic [REF_WIDTH-1:0] refs_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= sba_pkg::S_IDLE;
      pos           <= '0;
      found         <= 1'b0;
      acc           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state         <= state_next;
      pos           <= pos_next;
      found         <= found_next;
      acc           <= acc_next;
      m_axis_tvalid <= m_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    code     <= code_next;
    sel      <= sel_next;
    key_r    <= key_r_next;
    size_r   <= size_r_next;
    handle_r <= handle_r_next;
    out_idx  <= out_idx_next;
    res_idx  <= res_idx_next;
    res_code <= res_code_next;
  end

  // result register, loaded only when the previous result has gone
  assign m_axis_tdata = {(sba_pkg::OUT_DATA_W - sba_pkg::IDX_OUT_W)'(0), res_idx};
  assign m_axis_tuser = res_code;

  always_comb begin
    last     = (pos == IDX_W'(NUM_BLOCKS - 1));
    pos_inc  = last ? '0 : pos + 1'b1;
    start_x  = bitmap_mode ? CW'(START_CAP) : '0;
    ge_start = (CW'(pos) >= start_x);
    acc_add  = acc + AW'(BLOCK_BYTES);
    refs_dec = (head_refs == '0) ? '0 : head_refs - 1'b1;

    state_next    = state;
    code_next     = code;
    pos_next      = pos;
    sel_next      = sel;
    key_r_next    = key_r;
    size_r_next   = size_r;
    handle_r_next = handle_r;
    found_next    = found;
    acc_next      = acc;
    out_idx_next  = out_idx;
    res_idx_next  = res_idx;
    res_code_next = res_code;
    m_valid_next  = m_axis_tvalid && !m_axis_tready;
    tail_status   = head_status;
    tail_key      = head_key;
    tail_refs     = head_refs;
    shift         = 1'b0;
    s_axis_tready = (state == sba_pkg::S_IDLE);

    unique case (state)
      sba_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          key_r_next    = s_axis_tdata[31:0];
          size_r_next   = s_axis_tdata[47:32];
          handle_r_next = s_axis_tdata[57:48];
          found_next    = 1'b0;
          acc_next      = '0;
          code_next     = sba_pkg::OUT_IGNORED;
          state_next    = s_axis_tuser[0] ? sba_pkg::S_RELEASE : sba_pkg::S_MATCH;
        end
      end
      // lowest matching head gets its count raised in passing
      sba_pkg::S_MATCH: begin
        shift    = 1'b1;
        pos_next = pos_inc;
        if (!found && ge_start && head_status == sba_pkg::ST_HEAD && head_key == key_r) begin
          found_next = 1'b1;
          sel_next   = pos;
          if (head_refs != '1) begin
            tail_refs = head_refs + 1'b1;
          end
        end
        if (last) begin
          if (found_next) begin
            code_next    = sba_pkg::OUT_HIT;
            out_idx_next = 10'(sel_next);
            state_next   = sba_pkg::S_DONE;
          end else begin
            found_next = 1'b0;
            acc_next   = '0;
            state_next = sba_pkg::S_FIT;
          end
        end
      end
      // run length counted in bytes, so no division is needed
      sba_pkg::S_FIT: begin
        shift    = 1'b1;
        pos_next = pos_inc;
        if (!found) begin
          if (ge_start && head_status == sba_pkg::ST_FREE) begin
            if (acc == '0) begin
              sel_next = pos;
            end
            acc_next = acc_add;
            if (acc_add >= AW'(size_r)) begin
              found_next = 1'b1;
            end
          end else begin
            acc_next = '0;
          end
        end
        if (last) begin
          acc_next = '0;
          if (found_next) begin
            state_next = sba_pkg::S_MARK;
          end else begin
            code_next    = sba_pkg::OUT_OOM;
            out_idx_next = '0;
            state_next   = sba_pkg::S_DONE;
          end
        end
      end
      sba_pkg::S_MARK: begin
        shift    = 1'b1;
        pos_next = pos_inc;
        if (pos == sel) begin
          tail_status = sba_pkg::ST_HEAD;
          tail_key    = key_r;
          tail_refs   = REF_WIDTH'(1);
          acc_next    = AW'(BLOCK_BYTES);
        end else if (acc != '0) begin
          if (acc < AW'(size_r)) begin
            tail_status = sba_pkg::ST_CONT;
            acc_next    = acc_add;
          end else begin
            acc_next = '0;
          end
        end
        if (last) begin
          code_next    = sba_pkg::OUT_NEW;
          out_idx_next = 10'(sel);
          state_next   = sba_pkg::S_DONE;
        end
      end
      // found marks a run being freed after the handle
      sba_pkg::S_RELEASE: begin
        shift    = 1'b1;
        pos_next = pos_inc;
        if (CW'(pos) == CW'(handle_r)) begin
          if (head_status == sba_pkg::ST_HEAD) begin
            tail_refs = refs_dec;
            if (refs_dec == '0) begin
              tail_status = sba_pkg::ST_FREE;
              found_next  = 1'b1;
              code_next   = sba_pkg::OUT_RELEASED;
            end else begin
              code_next = sba_pkg::OUT_LOWERED;
            end
          end
        end else if (found) begin
          if (head_status == sba_pkg::ST_CONT) begin
            tail_status = sba_pkg::ST_FREE;
          end else begin
            found_next = 1'b0;
          end
        end
        if (last) begin
          out_idx_next = handle_r;
          state_next   = sba_pkg::S_DONE;
        end
      end
      sba_pkg::S_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          m_valid_next  = 1'b1;
          res_idx_next  = out_idx;
          res_code_next = code;
          state_next    = sba_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sba_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### rtl/sba_checker.sv
`include "assert_macros.svh"

module sba_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic        cfg_wdata,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [63:0] s_axis_tdata,
  input logic [0:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  // a stalled result holds
  `SBA_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  // one request at a time: taking one closes the input
  `SBA_ASSERT(a_one_at_a_time, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
  // out of memory reports block zero
  `SBA_ASSERT(a_oom_zero, m_axis_tvalid && m_axis_tuser == 3'(sba_pkg::OUT_OOM) |-> m_axis_tdata == 16'd0)
  // outcome codes stay in range
  `SBA_ASSERT(a_code_range, m_axis_tvalid |-> m_axis_tuser <= 3'(sba_pkg::OUT_IGNORED))
  // reset empties the output and opens the input
  `SBA_ASSERT_ALWAYS(a_reset, rst |=> !m_axis_tvalid && s_axis_tready)

endmodule

bind shared_block_allocator sba_checker u_sba_checker (.*);
